>>> hdl/gpvd_pkg.sv
// ----------------------------------------------------------------------------
// gpvd_pkg: shared types and constants for the grid peak/valley detector
// Field widths, result kinds, register indexes, back-end states.
// ----------------------------------------------------------------------------
package gpvd_pkg;

  localparam int DEF_MAX_COLS    = 128;
  localparam int DEF_HEIGHT_BITS = 16;

  localparam int ROW_W   = 12;
  localparam int COL_W   = 7;
  localparam int NCOL_W  = 8;
  localparam int CNT_W   = 20;
  localparam int SUM_W   = 48;
  localparam int IDX_W   = 1;
  localparam int CFG_W   = 12;
  localparam int MEAN_W  = 16;
  localparam int HOUT_W  = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_VALLEY  = 2'd0,
    KIND_PEAK    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  localparam logic [IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] REG_NUM_COLS = 1'd1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXT,
    BK_DIV,
    BK_SUM
  } bk_state_t;

endpackage

>>> hdl/grid_peak_valley_detect.sv
// ----------------------------------------------------------------------------
// grid_peak_valley_detect: 3x3 local peak/valley finder over a raster grid
// Top level: front end, job queue, back end with frame-mean divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, elevation) takes one sample per beat in
//   raster order. Output channel (out_valid/out_stall) carries result beats:
//   valley or peak reports for interior points, then one summary beat after
//   the frame's last sample (counts, mean truncated toward zero).
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   num_rows (0) and num_cols (1); any write restarts the frame.
// Throughput: one sample per cycle while the queue has room. A sample that
//   makes no result costs nothing downstream; an extremum passes two back-end
//   states (pick-up and emit); the summary waits on the one-bit-per-cycle
//   divider, and the four-entry queue absorbs the wait.
// Reset clears position, sums, counts and window; line buffers are not
//   cleared (entries read before written never reach a result).
// When the receiver stalls, the output register holds; the queue fills and
//   in_stall rises once fewer than two entries are free.
// ----------------------------------------------------------------------------
module grid_peak_valley_detect #(
  parameter int MAX_COLS    = gpvd_pkg::DEF_MAX_COLS,
  parameter int HEIGHT_BITS = gpvd_pkg::DEF_HEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [HEIGHT_BITS-1:0]     elevation,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic [gpvd_pkg::ROW_W-1:0]        row,
  output logic [gpvd_pkg::COL_W-1:0]        col,
  output logic signed [gpvd_pkg::HOUT_W-1:0] height,
  output logic [gpvd_pkg::CNT_W-1:0]        valley_total,
  output logic [gpvd_pkg::CNT_W-1:0]        peak_total,
  output logic signed [gpvd_pkg::MEAN_W-1:0] mean_height,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gpvd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [gpvd_pkg::CFG_W-1:0]        cfg_data
);
  import gpvd_pkg::*;

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int CNTW  = ROW_W + CW;
  localparam int QD    = 4;
  localparam int JW    = 1 + 1 + ROW_W + COL_W + HEIGHT_BITS + 1 + 2*CNT_W + SUM_W + CNTW;

  logic [ROW_W-1:0]  num_rows;
  logic [NCOL_W-1:0] num_cols;
  logic              cfg_fire, in_fire;

  // Front-end job record.
  logic                       f_valid, f_ext, f_peak, f_eof;
  logic [ROW_W-1:0]           f_row;
  logic [COL_W-1:0]           f_col;
  logic signed [HEIGHT_BITS-1:0] f_height;
  logic [CNT_W-1:0]           f_vcnt, f_pcnt;
  logic signed [SUM_W-1:0]    f_sum;
  logic [CNTW-1:0]            f_count;

  // Queue head as seen by the back end.
  logic                       q_valid, q_pop;
  logic [JW-1:0]              q_data;
  logic [$clog2(QD+1)-1:0]    q_fill;
  logic                       b_ext, b_peak, b_eof;
  logic [ROW_W-1:0]           b_row;
  logic [COL_W-1:0]           b_col;
  logic signed [HEIGHT_BITS-1:0] b_height;
  logic [CNT_W-1:0]           b_vcnt, b_pcnt;
  logic signed [SUM_W-1:0]    b_sum;
  logic [CNTW-1:0]            b_count;
  kind_t                      kind_e;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  // One job may be in flight in the front register; keep room for it.
  assign in_stall  = 32'(q_fill) + (f_valid ? 1 : 0) >= QD - 1;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= ROW_W'(100);
      num_cols <= NCOL_W'(100);
    end else if (cfg_fire) begin
      if (cfg_index == REG_NUM_ROWS) num_rows <= cfg_data;
      if (cfg_index == REG_NUM_COLS) num_cols <= cfg_data[NCOL_W-1:0];
    end
  end

  gpvd_front #(.MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk, .rst, .clear(cfg_fire), .num_rows, .num_cols, .in_fire, .elevation,
    .job_valid(f_valid), .job_ext(f_ext), .job_peak(f_peak), .job_row(f_row),
    .job_col(f_col), .job_height(f_height), .job_eof(f_eof), .job_vcnt(f_vcnt),
    .job_pcnt(f_pcnt), .job_sum(f_sum), .job_count(f_count)
  );

  gpvd_queue #(.W(JW), .DEPTH(QD)) u_queue (
    .clk, .rst, .push(f_valid),
    .push_data({f_ext, f_peak, f_row, f_col, f_height, f_eof, f_vcnt, f_pcnt, f_sum,
                f_count}),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_data), .fill(q_fill)
  );

  assign {b_ext, b_peak, b_row, b_col, b_height, b_eof, b_vcnt, b_pcnt, b_sum,
          b_count} = q_data;

  gpvd_back #(.HEIGHT_BITS(HEIGHT_BITS), .CNTW(CNTW)) u_back (
    .clk, .rst, .job_valid(q_valid), .job_pop(q_pop), .job_ext(b_ext),
    .job_peak(b_peak), .job_row(b_row), .job_col(b_col), .job_height(b_height),
    .job_eof(b_eof), .job_vcnt(b_vcnt), .job_pcnt(b_pcnt), .job_sum(b_sum),
    .job_count(b_count), .out_valid, .out_stall, .kind(kind_e), .row, .col,
    .height, .valley_total, .peak_total, .mean_height, .last
  );

  assign kind = kind_e;

endmodule

>>> hdl/gpvd_front.sv
// ----------------------------------------------------------------------------
// gpvd_front: line buffers, 3x3 window, position and extremum classification
// Accepts one sample per beat and pushes a job record for each extremum or frame end.
// ----------------------------------------------------------------------------
module gpvd_front #(
  parameter int MAX_COLS    = gpvd_pkg::DEF_MAX_COLS,
  parameter int HEIGHT_BITS = gpvd_pkg::DEF_HEIGHT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear,
  input  logic [gpvd_pkg::ROW_W-1:0]       num_rows,
  input  logic [gpvd_pkg::NCOL_W-1:0]      num_cols,
  input  logic                             in_fire,
  input  logic signed [HEIGHT_BITS-1:0]    elevation,
  output logic                             job_valid,
  output logic                             job_ext,
  output logic                             job_peak,
  output logic [gpvd_pkg::ROW_W-1:0]       job_row,
  output logic [gpvd_pkg::COL_W-1:0]       job_col,
  output logic signed [HEIGHT_BITS-1:0]    job_height,
  output logic                             job_eof,
  output logic [gpvd_pkg::CNT_W-1:0]       job_vcnt,
  output logic [gpvd_pkg::CNT_W-1:0]       job_pcnt,
  output logic signed [gpvd_pkg::SUM_W-1:0] job_sum,
  output logic [gpvd_pkg::ROW_W+$clog2(MAX_COLS+1)-1:0] job_count
);
  import gpvd_pkg::*;

  localparam int AW  = $clog2(MAX_COLS);
  localparam int CW  = $clog2(MAX_COLS + 1);

  logic signed [HEIGHT_BITS-1:0] mem_a [MAX_COLS];
  logic signed [HEIGHT_BITS-1:0] mem_b [MAX_COLS];
  logic signed [HEIGHT_BITS-1:0] win [3][3];
  logic [ROW_W-1:0] row_index;
  logic [CW-1:0]    col_index;
  logic signed [SUM_W-1:0] height_sum;
  logic [CNT_W-1:0] valley_tally, peak_tally;

  logic [ROW_W-1:0] rows_eff;
  logic [CW-1:0]    cols_eff;
  logic [AW-1:0]    ca;
  logic [AW-1:0]    ra;
  logic signed [HEIGHT_BITS-1:0] rd_a, rd_b;
  logic signed [HEIGHT_BITS-1:0] ctr;
  logic lo, hi, interior, eof, ext;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] vc_next, pc_next;

  always_comb begin
    rows_eff = (num_rows == '0) ? ROW_W'(1) : num_rows;
    if (num_cols == '0) cols_eff = CW'(1);
    else if (32'(num_cols) > MAX_COLS) cols_eff = CW'(MAX_COLS);
    else cols_eff = CW'(num_cols);
  end

  assign ca = AW'(col_index);

  // Line buffer read address for the next beat's column; data is registered.
  always_comb begin
    if (rst || clear) ra = '0;
    else if (in_fire) ra = (col_index + CW'(1) >= cols_eff) ? '0 : AW'(col_index + CW'(1));
    else ra = ca;
  end

  // Window after this sample shifts in; centre is the old column 2 of row 1.
  always_comb begin
    ctr = win[1][2];
    lo  = 1'b1;
    hi  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [HEIGHT_BITS-1:0] nb;
        nb = (j < 2) ? win[i][j+1] : ((i == 0) ? rd_b : ((i == 1) ? rd_a : elevation));
        if (!(i == 1 && j == 1)) begin
          if (!(ctr < nb)) lo = 1'b0;
          if (!(ctr > nb)) hi = 1'b0;
        end
      end
    end
    interior = (row_index >= ROW_W'(2)) && (col_index >= CW'(2));
    ext      = interior && (lo || hi);
    eof      = (row_index >= rows_eff - ROW_W'(1)) && (col_index >= cols_eff - CW'(1));
    sum_next = height_sum + SUM_W'(elevation);
    vc_next  = valley_tally;
    pc_next  = peak_tally;
    if (ext && lo && valley_tally != CNT_MAX) vc_next = valley_tally + CNT_W'(1);
    if (ext && !lo && peak_tally != CNT_MAX)  pc_next = peak_tally + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_b[ca] <= rd_a;
      mem_a[ca] <= elevation;
    end
    rd_a <= mem_a[ra];
    rd_b <= mem_b[ra];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_index    <= '0;
      col_index    <= '0;
      height_sum   <= '0;
      valley_tally <= '0;
      peak_tally   <= '0;
      for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] <= '0;
    end else if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= rd_b;
      win[1][2] <= rd_a;
      win[2][2] <= elevation;
      if (eof) begin
        row_index    <= '0;
        col_index    <= '0;
        height_sum   <= '0;
        valley_tally <= '0;
        peak_tally   <= '0;
        for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] <= '0;
      end else begin
        height_sum   <= sum_next;
        valley_tally <= vc_next;
        peak_tally   <= pc_next;
        if (col_index + CW'(1) >= cols_eff) begin
          col_index <= '0;
          row_index <= row_index + ROW_W'(1);
        end else begin
          col_index <= col_index + CW'(1);
        end
      end
    end
  end

  // Job record, registered.
  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else     job_valid <= in_fire && (ext || eof);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_ext    <= ext;
      job_peak   <= !lo;
      job_row    <= row_index - ROW_W'(1);
      job_col    <= COL_W'(col_index - CW'(1));
      job_height <= ctr;
      job_eof    <= eof;
      job_vcnt   <= vc_next;
      job_pcnt   <= pc_next;
      job_sum    <= sum_next;
      job_count  <= (ROW_W+CW)'(rows_eff) * (ROW_W+CW)'(cols_eff);
    end
  end

endmodule

>>> hdl/gpvd_queue.sv
// ----------------------------------------------------------------------------
// gpvd_queue: small FIFO of job records between front and back ends
// Holds packed jobs; reports its fill level so the front can stall early.
// ----------------------------------------------------------------------------
module gpvd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data,
  output logic [$clog2(DEPTH+1)-1:0] fill
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;

  assign not_empty = fill != '0;
  assign pop_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= (32'(wp) == DEPTH - 1) ? '0 : wp + AW'(1);
      if (pop)  rp <= (32'(rp) == DEPTH - 1) ? '0 : rp + AW'(1);
      fill <= fill + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

endmodule

>>> hdl/gpvd_back.sv
// ----------------------------------------------------------------------------
// gpvd_back: turns job records into result beats, runs the frame-mean divider
// Restoring divider, one quotient bit per cycle, output register on the port.
// ----------------------------------------------------------------------------
module gpvd_back #(
  parameter int HEIGHT_BITS = gpvd_pkg::DEF_HEIGHT_BITS,
  parameter int CNTW        = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_pop,
  input  logic                              job_ext,
  input  logic                              job_peak,
  input  logic [gpvd_pkg::ROW_W-1:0]        job_row,
  input  logic [gpvd_pkg::COL_W-1:0]        job_col,
  input  logic signed [HEIGHT_BITS-1:0]     job_height,
  input  logic                              job_eof,
  input  logic [gpvd_pkg::CNT_W-1:0]        job_vcnt,
  input  logic [gpvd_pkg::CNT_W-1:0]        job_pcnt,
  input  logic signed [gpvd_pkg::SUM_W-1:0] job_sum,
  input  logic [CNTW-1:0]                   job_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gpvd_pkg::kind_t                   kind,
  output logic [gpvd_pkg::ROW_W-1:0]        row,
  output logic [gpvd_pkg::COL_W-1:0]        col,
  output logic signed [gpvd_pkg::HOUT_W-1:0] height,
  output logic [gpvd_pkg::CNT_W-1:0]        valley_total,
  output logic [gpvd_pkg::CNT_W-1:0]        peak_total,
  output logic signed [gpvd_pkg::MEAN_W-1:0] mean_height,
  output logic                              last
);
  import gpvd_pkg::*;

  localparam int QW = SUM_W;
  localparam int SW = $clog2(QW + 1);

  bk_state_t state, state_next;
  logic [QW-1:0]   quo, rem_r;
  logic [CNTW-1:0] dvs;
  logic [SW-1:0]   step;
  logic            neg;
  logic [QW:0]     trial;
  logic            out_free, emit_ext, emit_sum, div_start;
  logic signed [QW-1:0] mean_s;

  assign out_free = !out_valid || !out_stall;
  assign trial    = {rem_r, quo[QW-1]} - (QW+1)'(dvs);
  assign mean_s   = neg ? -$signed(quo) : $signed(quo);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_valid) state_next = job_ext ? BK_EXT : BK_DIV;
      BK_EXT:  if (out_free) state_next = job_eof ? BK_DIV : BK_IDLE;
      BK_DIV:  if (step == SW'(QW)) state_next = BK_SUM;
      BK_SUM:  if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    emit_ext  = (state == BK_EXT) && out_free;
    emit_sum  = (state == BK_SUM) && out_free;
    job_pop   = emit_sum || (emit_ext && !job_eof);
    div_start = (state == BK_IDLE && job_valid && !job_ext) || (emit_ext && job_eof);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg   <= job_sum[QW-1];
      quo   <= job_sum[QW-1] ? QW'(-job_sum) : QW'(job_sum);
      rem_r <= '0;
      dvs   <= job_count;
      step  <= '0;
    end else if (state == BK_DIV && step != SW'(QW)) begin
      step <= step + SW'(1);
      if (!trial[QW]) begin
        rem_r <= trial[QW-1:0];
        quo   <= {quo[QW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[QW-2:0], quo[QW-1]};
        quo   <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_free) out_valid <= emit_ext || emit_sum;
  end

  always_ff @(posedge clk) begin
    if (emit_ext) begin
      kind         <= job_peak ? KIND_PEAK : KIND_VALLEY;
      row          <= job_row;
      col          <= job_col;
      height       <= HOUT_W'(job_height);
      valley_total <= '0;
      peak_total   <= '0;
      mean_height  <= '0;
      last         <= !job_eof;
    end else if (emit_sum) begin
      kind         <= KIND_SUMMARY;
      row          <= '0;
      col          <= '0;
      height       <= '0;
      valley_total <= job_vcnt;
      peak_total   <= job_pcnt;
      mean_height  <= MEAN_W'(mean_s);
      last         <= 1'b1;
    end
  end

endmodule

>>> tb/sv/grid_peak_valley_detect_tb.sv
// ----------------------------------------------------------------------------
// grid_peak_valley_detect_tb: self-checking bench for the 3x3 extremum finder
// Streams elevation frames through the block and predicts every valley, peak
// and frame summary beat. Covers directed corner frames, then random frames
// under several idle/stall mixes, with register changes between phases.
// ----------------------------------------------------------------------------
module grid_peak_valley_detect_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpvd_pkg::*;

  localparam int NCOLS_MAX  = 128;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 80;

  // result beat as the block should present it
  typedef struct {
    kind_t                     kind;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [HOUT_W-1:0]  height;
    logic [CNT_W-1:0]          valley_total;
    logic [CNT_W-1:0]          peak_total;
    logic signed [MEAN_W-1:0]  mean_height;
    logic                      last;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] elevation = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic signed [HOUT_W-1:0] height;
  logic [CNT_W-1:0] valley_total, peak_total;
  logic signed [MEAN_W-1:0] mean_height;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = REG_NUM_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  grid_peak_valley_detect i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .elevation(elevation),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .row(row), .col(col), .height(height),
    .valley_total(valley_total), .peak_total(peak_total),
    .mean_height(mean_height), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shadow of the detector: registers, line buffers, window, frame totals
  // --------------------------------------------------------------------------
  int unsigned rows_reg = 100, cols_reg = 100;
  logic signed [15:0] lb_one [NCOLS_MAX];
  logic signed [15:0] lb_two [NCOLS_MAX];
  logic signed [15:0] win [3][3];
  int unsigned cur_row, cur_col;
  longint frame_sum;
  int unsigned valleys, peaks;

  grid_result_t awaited [$];        // beats still owed by the block
  logic signed [15:0] samples [$];  // samples not yet presented

  int unsigned n_err, n_samples, n_extrema, n_summaries, n_cfg;
  int unsigned cycles;
  int unsigned idle_pct, stall_pct;
  bit hold_off;
  bit in_taken;

  function automatic int unsigned frame_rows();
    return (rows_reg == 0) ? 1 : rows_reg;
  endfunction

  function automatic int unsigned frame_cols();
    int unsigned n;
    n = (cols_reg == 0) ? 1 : cols_reg;
    return (n > NCOLS_MAX) ? NCOLS_MAX : n;
  endfunction

  function automatic void restart_frame();
    foreach (win[i, j]) win[i][j] = '0;
    cur_row = 0;
    cur_col = 0;
    frame_sum = 0;
    valleys = 0;
    peaks = 0;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_NUM_ROWS) rows_reg = val;
    else rows_reg = rows_reg;
    if (idx == REG_NUM_COLS) cols_reg = val[7:0];
    restart_frame();
  endfunction

  // one sample in: shift window, update line buffers, emit owed beats
  function automatic void grid_step(logic signed [15:0] x);
    int unsigned r, c;
    logic signed [15:0] ctr;
    bit lo, hi, any;
    grid_result_t ext, summ;
    r = cur_row;
    c = cur_col;
    any = 0;
    if (c >= NCOLS_MAX) c = 0;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = lb_two[c];
    win[1][2] = lb_one[c];
    win[2][2] = x;
    lb_two[c] = lb_one[c];
    lb_one[c] = x;
    frame_sum += x;

    // interior center: strict compare against all eight neighbors
    if (r >= 2 && c >= 2) begin
      ctr = win[1][1];
      lo = 1;
      hi = 1;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (!(i == 1 && j == 1)) begin
            if (!(ctr < win[i][j])) lo = 0;
            if (!(ctr > win[i][j])) hi = 0;
          end
      if (lo || hi) begin
        if (lo && valleys < CNT_MAX) valleys++;
        if (!lo && peaks < CNT_MAX) peaks++;
        ext = '{lo ? KIND_VALLEY : KIND_PEAK, ROW_W'(r - 1), COL_W'(c - 1), ctr,
                '0, '0, '0, 1'b0};
        any = 1;
        n_extrema++;
      end
    end

    if (r >= frame_rows() - 1 && c >= frame_cols() - 1) begin
      if (any) awaited.push_back(ext);
      summ = '{KIND_SUMMARY, '0, '0, '0, CNT_W'(valleys), CNT_W'(peaks),
               MEAN_W'(frame_sum / longint'(frame_rows() * frame_cols())), 1'b1};
      awaited.push_back(summ);
      n_summaries++;
      restart_frame();
    end else begin
      if (any) begin
        ext.last = 1'b1;
        awaited.push_back(ext);
      end
      if (c + 1 >= frame_cols()) begin
        cur_col = 0;
        cur_row = (r + 1) & 12'hFFF;
      end else begin
        cur_col = c + 1;
      end
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_err++;
    $display("mismatch %s: got %0d, expected %0d (at cycle %0d)", what, got, want, cycles);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one sample per beat from the pending queue; out_stall at random
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    logic nv;
    logic signed [15:0] ne;
    nv = in_valid;
    ne = elevation;
    if (in_valid && in_taken) nv = 1'b0;
    if (!nv && !rst && !hold_off && samples.size() > 0 &&
        $urandom_range(99) >= idle_pct) begin
      ne = samples.pop_front();
      nv = 1'b1;
    end
    in_valid <= nv;
    elevation <= ne;
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input beats, check output beats in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    grid_result_t w;
    cycles++;
    in_taken = in_valid && !in_stall && !rst;
    if (in_taken) begin
      n_samples++;
      grid_step(elevation);
    end
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        report_mismatch("unexpected beat, kind", longint'(kind), -1);
      end else begin
        w = awaited.pop_front();
        if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
        if (row !== w.row) report_mismatch("row", row, w.row);
        if (col !== w.col) report_mismatch("col", col, w.col);
        if (height !== w.height) report_mismatch("height", height, w.height);
        if (valley_total !== w.valley_total)
          report_mismatch("valley_total", valley_total, w.valley_total);
        if (peak_total !== w.peak_total)
          report_mismatch("peak_total", peak_total, w.peak_total);
        if (mean_height !== w.mean_height)
          report_mismatch("mean_height", mean_height, w.mean_height);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, awaited.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------

  // block idle: everything presented, every owed beat seen, then a pause
  // for work that owes nothing (a partial frame still in the pipe)
  task automatic settle();
    while (samples.size() > 0 || in_valid || awaited.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(int unsigned nr, int unsigned nc);
    settle();
    write_reg(REG_NUM_ROWS, CFG_W'(nr));
    write_reg(REG_NUM_COLS, CFG_W'(nc));
  endtask

  // sample flavors: full range, narrow range (ties), rail values, gentle hills
  function automatic logic signed [15:0] pick_height(int unsigned flavor);
    case (flavor)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(6)) - 3);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return -16'sd1;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  task automatic queue_frames(int unsigned nframes);
    int unsigned flavor;
    repeat (nframes) begin
      flavor = $urandom_range(3);
      repeat (frame_rows() * frame_cols()) samples.push_back(pick_height(flavor));
    end
  endtask

  task automatic queue_list(logic signed [15:0] vals [$]);
    foreach (vals[i]) samples.push_back(vals[i]);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : seq
    int unsigned phase_idle [4] = '{0, 72, 0, 72};
    int unsigned phase_stall [4] = '{0, 0, 72, 23};
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    foreach (lb_one[i]) begin
      lb_one[i] = '0;
      lb_two[i] = '0;
    end
    restart_frame();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: 3x3 frames, extremum lands on the frame's final sample
    set_grid(3, 3);
    queue_list('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0,
                 16'sd0, 16'sd0, 16'sd0});          // rail peak
    queue_list('{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0,
                 16'sd0, 16'sd0, 16'sd0});          // valley at -1
    // 1x1 frames through zero registers
    set_grid(0, 0);
    queue_list('{16'sh8000, 16'sh7FFF});
    // too few rows: summary only, mean of negatives rounds toward zero
    set_grid(2, 3);
    queue_list('{-16'sd1, -16'sd2, 16'sd0, 16'sh8000, 16'sd0, -16'sd4});

    // random frames under each idle mix, a fresh grid each time
    for (int p = 0; p < 4; p++) begin
      set_grid($urandom_range(3, 9), $urandom_range(3, 16));
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      queue_frames(2);
      settle();
      // hold the sender until the block has drained
      set_grid($urandom_range(1, 6), $urandom_range(1, 40));
      queue_frames(1);
      hold_off = 1;
      while (awaited.size() > 0 || in_valid) @(posedge clk);
      hold_off = 0;
    end

    // extremes: widest rows through an oversized column count, huge row
    // count cut short, single-column frame
    idle_pct = 23;
    stall_pct = 23;
    set_grid(3, 255);
    queue_frames(1);
    set_grid(4095, 255);
    queue_frames(1);
    samples = samples[0:99];
    set_grid(4095, 1);
    repeat (40) samples.push_back(pick_height(0));
    settle();

    $display("covered %0d samples in %0d register writes: %0d extrema, %0d summaries",
             n_samples, n_cfg, n_extrema, n_summaries);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_err);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
